// ===== rtl/core/moving_average_window_assert.svh =====
// assertion macros for the moving average block
`ifndef MOVING_AVERAGE_WINDOW_ASSERT_SVH
`define MOVING_AVERAGE_WINDOW_ASSERT_SVH

// same-cycle implication
`define MAVG_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAVG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mavg_pkg.sv =====
// types, constants and microcode table of the moving average block
package mavg_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int WINDOW_MAX   = 64;
  localparam int WIN_BITS     = 7;
  localparam int POS_BITS     = 6;
  localparam int SUM_BITS     = 23;
  localparam int MAG_BITS     = 22;
  localparam int DIV_CNT_BITS = 5;

  typedef logic [2:0] step_t;

  localparam step_t STEP_WAIT     = 3'd0;
  localparam step_t STEP_CHECK    = 3'd1;
  localparam step_t STEP_UPDATE   = 3'd2;
  localparam step_t STEP_DIV_INIT = 3'd3;
  localparam step_t STEP_DIV_LOOP = 3'd4;
  localparam step_t STEP_EMIT     = 3'd5;
  localparam step_t STEP_RETURN   = 3'd6;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_WIN_ZERO,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  rd_ring;
    logic  update;
    logic  div_init;
    logic  div_step;
    logic  emit;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic win_zero;
    logic div_more;
    logic out_busy;
  } status_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{accept: 1'b0, rd_ring: 1'b0, update: 1'b0, div_init: 1'b0,
          div_step: 1'b0, emit: 1'b0, cond: COND_NONE, target: STEP_WAIT};
    case (step)
      STEP_WAIT: begin
        w.accept  = 1'b1;
        w.rd_ring = 1'b1;
        w.cond    = COND_NO_INPUT;
        w.target  = STEP_WAIT;
      end
      STEP_CHECK: begin
        w.cond   = COND_WIN_ZERO;
        w.target = STEP_EMIT;
      end
      STEP_UPDATE: begin
        w.update = 1'b1;
      end
      STEP_DIV_INIT: begin
        w.div_init = 1'b1;
      end
      STEP_DIV_LOOP: begin
        w.div_step = 1'b1;
        w.cond     = COND_DIV_MORE;
        w.target   = STEP_DIV_LOOP;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/mavg_ifs.sv =====
// valid/ready stream interfaces for samples and averages
interface mavg_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mavg_pkg::SAMPLE_BITS-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface mavg_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mavg_pkg::SAMPLE_BITS-1:0] average;
  logic        [mavg_pkg::WIN_BITS-1:0]    fill_count;

  modport source(output valid, output average, output fill_count, input ready);
  modport sink(input valid, input average, input fill_count, output ready);
endinterface

// ===== rtl/core/mavg_seq.sv =====
// microcode sequencer: step counter, control table and conditional jumps
module mavg_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  mavg_pkg::status_t status,
  output mavg_pkg::ctrl_t   ctrl
);

  mavg_pkg::step_t upc_r;
  mavg_pkg::step_t upc_nxt;
  logic            take_jump;

  assign ctrl = mavg_pkg::ucode(upc_r);

  always_comb begin
    case (ctrl.cond)
      mavg_pkg::COND_NONE:     take_jump = 1'b0;
      mavg_pkg::COND_ALWAYS:   take_jump = 1'b1;
      mavg_pkg::COND_NO_INPUT: take_jump = !status.in_valid;
      mavg_pkg::COND_WIN_ZERO: take_jump = status.win_zero;
      mavg_pkg::COND_DIV_MORE: take_jump = status.div_more;
      mavg_pkg::COND_OUT_BUSY: take_jump = status.out_busy;
      default:                 take_jump = 1'b0;
    endcase
    upc_nxt = take_jump ? ctrl.target : mavg_pkg::step_t'(upc_r + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= mavg_pkg::STEP_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== rtl/core/mavg_ring.sv =====
// sample ring store, one write and one registered read port
module mavg_ring (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [mavg_pkg::POS_BITS-1:0]           waddr,
  input  logic [mavg_pkg::SAMPLE_BITS-1:0]        wdata,
  input  logic                                   re,
  input  logic [mavg_pkg::POS_BITS-1:0]           raddr,
  output logic [mavg_pkg::SAMPLE_BITS-1:0]        rdata
);

  logic [mavg_pkg::SAMPLE_BITS-1:0] mem [mavg_pkg::WINDOW_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mavg_div.sv =====
// restoring divider, one quotient bit per step
module mavg_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              init,
  input  logic                              step,
  input  logic [mavg_pkg::MAG_BITS-1:0]     dividend,
  input  logic [mavg_pkg::WIN_BITS-1:0]     divisor,
  output logic [mavg_pkg::MAG_BITS-1:0]     quotient,
  output logic                              more
);

  logic [mavg_pkg::MAG_BITS-1:0]     quo_r;
  logic [mavg_pkg::WIN_BITS-1:0]     rem_r;
  logic [mavg_pkg::WIN_BITS-1:0]     dvs_r;
  logic [mavg_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic [mavg_pkg::WIN_BITS:0]       shifted;
  logic [mavg_pkg::WIN_BITS:0]       diff;
  logic                              fits;

  always_comb begin
    shifted = {rem_r, quo_r[mavg_pkg::MAG_BITS-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = shifted >= {1'b0, dvs_r};
  end

  assign quotient = quo_r;
  assign more     = cnt_r != mavg_pkg::DIV_CNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (init) begin
      cnt_r <= mavg_pkg::DIV_CNT_BITS'(mavg_pkg::MAG_BITS);
    end else if (step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (step) begin
      quo_r <= {quo_r[mavg_pkg::MAG_BITS-2:0], fits};
      rem_r <= fits ? diff[mavg_pkg::WIN_BITS-1:0] : shifted[mavg_pkg::WIN_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/moving_average_window.sv =====
// Simple moving average over the last window_length samples (capped at 64).
// Each accepted sample yields one result: the running sum divided by the
// number of samples held, truncated toward zero, plus that count. After the
// sample's transfer the sequencer steps through a window check, the ring
// write and sum update, the divider load, one step of the bit-serial divider
// per bit of the 22-bit sum magnitude by the fill count, and the output load.
// A return step then brings the sequencer back to idle, and only there is a
// new sample accepted. With window 0 the check goes straight to the output
// load. The next sample is accepted while a result still waits in the output
// register; its own result then holds the sequencer until the first is taken.
// Window 0 ignores samples and reports 0 with a count of 0. Any write of
// cfg_wdata empties the window; write it only while the block is idle.
`include "moving_average_window_assert.svh"

module moving_average_window (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mavg_pkg::WIN_BITS-1:0]    cfg_wdata,
  mavg_in_if.sink                          in_chan,
  mavg_out_if.source                       out_chan
);

  mavg_pkg::ctrl_t   ctrl;
  mavg_pkg::status_t status;

  logic        [mavg_pkg::WIN_BITS-1:0]    wl_r;
  logic        [mavg_pkg::POS_BITS-1:0]    pos_r;
  logic        [mavg_pkg::WIN_BITS-1:0]    held_r;
  logic signed [mavg_pkg::SUM_BITS-1:0]    sum_r;
  logic        [mavg_pkg::SAMPLE_BITS-1:0] sample_r;
  logic                                    neg_r;
  logic                                    out_valid_r;
  logic        [mavg_pkg::SAMPLE_BITS-1:0] avg_r;
  logic        [mavg_pkg::WIN_BITS-1:0]    fill_r;

  logic        [mavg_pkg::POS_BITS-1:0]    pos_nxt;
  logic        [mavg_pkg::WIN_BITS-1:0]    held_nxt;
  logic signed [mavg_pkg::SUM_BITS-1:0]    sum_nxt;
  logic                                    out_valid_nxt;
  logic        [mavg_pkg::SAMPLE_BITS-1:0] avg_nxt;

  logic [mavg_pkg::WIN_BITS-1:0]    win_n;
  logic [mavg_pkg::POS_BITS-1:0]    pos_eff;
  logic [mavg_pkg::WIN_BITS-1:0]    pos_inc;
  logic                             full;
  logic [mavg_pkg::SAMPLE_BITS-1:0] old_sample;
  logic [mavg_pkg::SUM_BITS-1:0]    old_ext;
  logic [mavg_pkg::SUM_BITS-1:0]    new_ext;
  logic [mavg_pkg::SUM_BITS-1:0]    sum_abs;
  logic [mavg_pkg::MAG_BITS-1:0]    quotient;
  logic [mavg_pkg::SAMPLE_BITS-1:0] quo_low;
  logic                             div_more;
  logic                             in_xfer;
  logic                             out_busy;
  logic                             emit_fire;

  // effective window and write slot
  always_comb begin
    win_n   = (wl_r > mavg_pkg::WIN_BITS'(mavg_pkg::WINDOW_MAX))
              ? mavg_pkg::WIN_BITS'(mavg_pkg::WINDOW_MAX) : wl_r;
    pos_eff = ({1'b0, pos_r} >= win_n) ? '0 : pos_r;
    pos_inc = {1'b0, pos_eff} + 1'b1;
    full    = held_r >= win_n;
  end

  assign in_xfer   = in_chan.valid && ctrl.accept;
  assign out_busy  = out_valid_r && !out_chan.ready;
  assign emit_fire = ctrl.emit && !out_busy;

  assign status = '{in_valid: in_chan.valid, win_zero: win_n == '0,
                    div_more: div_more, out_busy: out_busy};

  mavg_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  mavg_ring u_ring (
    .clk   (clk),
    .we    (ctrl.update),
    .waddr (pos_eff),
    .wdata (sample_r),
    .re    (ctrl.rd_ring),
    .raddr (pos_eff),
    .rdata (old_sample)
  );

  always_comb begin
    sum_abs = sum_r[mavg_pkg::SUM_BITS-1] ? (~sum_r + 1'b1) : sum_r;
  end

  mavg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .init     (ctrl.div_init),
    .step     (ctrl.div_step),
    .dividend (sum_abs[mavg_pkg::MAG_BITS-1:0]),
    .divisor  (held_r),
    .quotient (quotient),
    .more     (div_more)
  );

  // window update: add new sample, drop displaced one once full
  always_comb begin
    new_ext  = {{(mavg_pkg::SUM_BITS-mavg_pkg::SAMPLE_BITS){sample_r[mavg_pkg::SAMPLE_BITS-1]}},
                sample_r};
    old_ext  = full
               ? {{(mavg_pkg::SUM_BITS-mavg_pkg::SAMPLE_BITS){old_sample[mavg_pkg::SAMPLE_BITS-1]}},
                  old_sample}
               : '0;
    sum_nxt  = sum_r + $signed(new_ext) - $signed(old_ext);
    pos_nxt  = (pos_inc >= win_n) ? '0 : pos_inc[mavg_pkg::POS_BITS-1:0];
    held_nxt = full ? held_r : held_r + 1'b1;
  end

  always_comb begin
    quo_low = quotient[mavg_pkg::SAMPLE_BITS-1:0];
    if (win_n == '0) begin
      avg_nxt = '0;
    end else begin
      avg_nxt = neg_r ? (~quo_low + 1'b1) : quo_low;
    end
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_chan.ready       = ctrl.accept;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.average    = avg_r;
  assign out_chan.fill_count = fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= '0;
      pos_r       <= '0;
      held_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        wl_r   <= cfg_wdata;
        pos_r  <= '0;
        held_r <= '0;
        sum_r  <= '0;
      end else if (ctrl.update) begin
        pos_r  <= pos_nxt;
        held_r <= held_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= in_chan.sample;
    end
    if (ctrl.div_init) begin
      neg_r <= sum_r[mavg_pkg::SUM_BITS-1];
    end
    if (emit_fire) begin
      avg_r  <= avg_nxt;
      fill_r <= held_r;
    end
  end

  `MAVG_ASSERT_NOW(a_held_in_window, 1'b1, held_r <= win_n,
                   "fill count exceeds window")
  `MAVG_ASSERT_NOW(a_pos_in_window, 1'b1, (win_n == '0) || ({1'b0, pos_r} < win_n),
                   "write position outside window")
  `MAVG_ASSERT_NOW(a_divisor_nonzero, ctrl.div_init, held_r != '0,
                   "divide started with empty window")
  `MAVG_ASSERT_NXT(a_emit_loads_output, emit_fire, out_valid_r && (fill_r == $past(held_r)),
                   "result not loaded into output register")

endmodule
